/* hw/rtl/multichar_delimiter_splitter_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the delimiter splitter checker
// Each macro wraps one concurrent check, clocked on clk and muted in reset.
// ----------------------------------------------------------------------------
`ifndef MULTICHAR_DELIMITER_SPLITTER_TOP_ASSERT_SVH
`define MULTICHAR_DELIMITER_SPLITTER_TOP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define MDS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define MDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/mds_pkg.sv */
// ----------------------------------------------------------------------------
// mds_pkg
// Shared types and constants of the multi-byte delimiter splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mds_pkg;

  // Default sizing
  localparam int MAX_DELIM_LEN_DEF = 8;
  localparam int MAX_TOKENS_DEF    = 256;

  // Register port geometry: two 64-bit registers at byte addresses 0 and 8
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int REG_SEL_BIT = 3;

  // Register indexes
  localparam logic REG_DELIM_BYTES = 1'b0;
  localparam logic REG_DELIM_LEN   = 1'b1;

  // Register reset values: a single space
  localparam logic [63:0] DELIM_BYTES_RST = 64'd32;
  localparam logic [3:0]  DELIM_LEN_RST   = 4'd1;

  typedef struct packed {
    logic [63:0] delim_bytes;
    logic [3:0]  delim_len;
  } cfg_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] index;
    logic       tend;
    logic       send;
    logic       none;
  } res_t;

  typedef enum logic [1:0] {
    PH_ENTRY,
    PH_DRAIN,
    PH_FLUSH
  } phase_t;

endpackage

/* hw/rtl/mds_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mds_cfg_regs
// Register port: delimiter bytes and delimiter length, written and read back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mds_cfg_regs
  import mds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [63:0] delim_bytes_r;
  logic [3:0]  delim_len_r;
  logic        wr_en;
  logic        reg_sel;

  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[REG_SEL_BIT];
  assign pready  = 1'b1;

  // Write on the access beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_bytes_r <= DELIM_BYTES_RST;
      delim_len_r   <= DELIM_LEN_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_DELIM_BYTES: delim_bytes_r <= pwdata;
        REG_DELIM_LEN:   delim_len_r   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_DELIM_BYTES: prdata = delim_bytes_r;
      REG_DELIM_LEN:   prdata = {{(CFG_DATA_W-4){1'b0}}, delim_len_r};
      default:         prdata = '0;
    endcase
  end

  assign cfg.delim_bytes = delim_bytes_r;
  assign cfg.delim_len   = delim_len_r;

endmodule

/* hw/rtl/mds_in_skid.sv */
// ----------------------------------------------------------------------------
// mds_in_skid
// Two-entry input buffer: a head beat for the core and a spare that
// catches a beat while the head is still being worked on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mds_in_skid
  import mds_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       item_done,
  output item_t      cur
);

  item_t head_r, head_nxt;
  item_t spare_r, spare_nxt;
  logic  accept;
  logic  head_free;

  assign in_stall  = spare_r.vld;
  assign accept    = in_valid & ~spare_r.vld;
  assign head_free = ~head_r.vld | item_done;
  assign cur       = head_r;

  // Advance the head from the spare or from the port
  always_comb begin
    head_nxt  = head_r;
    spare_nxt = spare_r;
    if (head_free) begin
      if (spare_r.vld) begin
        head_nxt      = spare_r;
        spare_nxt.vld = 1'b0;
      end else if (accept) begin
        head_nxt = '{vld: 1'b1, data: in_byte, last: in_last};
      end else begin
        head_nxt.vld = 1'b0;
      end
    end else if (accept) begin
      spare_nxt = '{vld: 1'b1, data: in_byte, last: in_last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.vld  <= 1'b0;
      spare_r.vld <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      spare_r <= spare_nxt;
    end
  end

endmodule

/* hw/rtl/mds_core.sv */
// ----------------------------------------------------------------------------
// mds_core
// Match window, held token byte and token counter, stepped once per cycle unless
// no byte is present or a stalled result is held, with the result register on its output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mds_core
  import mds_pkg::*;
#(
  parameter int MAX_DELIM_LEN = MAX_DELIM_LEN_DEF,
  parameter int MAX_TOKENS    = MAX_TOKENS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  item_t cur,
  output logic  item_done,
  input  logic  out_stall,
  output logic  out_valid,
  output res_t  out_res
);

  localparam int          FILL_W    = $clog2(MAX_DELIM_LEN + 1);
  localparam int          IDX_MAX_I = (MAX_TOKENS - 1 > 255) ? 255 : MAX_TOKENS - 1;
  localparam logic [7:0]  IDX_MAX   = 8'(IDX_MAX_I);
  localparam logic [3:0]  MAX_LEN4  = 4'(MAX_DELIM_LEN);
  localparam logic [FILL_W-1:0] MAX_FILL = FILL_W'(MAX_DELIM_LEN);

  logic [7:0]        win_r [MAX_DELIM_LEN];
  logic [7:0]        win_nxt [MAX_DELIM_LEN];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0]        held_r, held_nxt;
  logic              held_vld_r, held_vld_nxt;
  logic [7:0]        cnt_r, cnt_nxt;
  logic              in_tok_r, in_tok_nxt;
  phase_t            phase_r, phase_nxt;
  logic              out_vld_r, out_vld_nxt;
  res_t              out_r, out_nxt;

  logic [3:0]        len_clamp;
  logic [FILL_W-1:0] len_eff;
  logic [7:0]        wk [MAX_DELIM_LEN];
  logic [7:0]        wk_pop [MAX_DELIM_LEN];
  logic [FILL_W-1:0] wf;
  logic              mismatch;
  logic              advance;
  logic              do_pop;
  logic              done;
  logic              emit;
  res_t              emit_res;

  // Clamp the configured length to 1..MAX_DELIM_LEN
  always_comb begin
    if (cfg.delim_len == 4'd0) begin
      len_clamp = 4'd1;
    end else if (cfg.delim_len > MAX_LEN4) begin
      len_clamp = MAX_LEN4;
    end else begin
      len_clamp = cfg.delim_len;
    end
  end

  assign len_eff = FILL_W'(len_clamp);

  // Working window: append the new byte on entry, compare, and shift view
  always_comb begin
    wk = win_r;
    wf = fill_r;
    if (phase_r == PH_ENTRY && fill_r < MAX_FILL) begin
      for (int i = 0; i < MAX_DELIM_LEN; i++) begin
        if (FILL_W'(i) == fill_r) begin
          wk[i] = cur.data;
        end
      end
      wf = fill_r + FILL_W'(1);
    end
    mismatch = 1'b0;
    for (int i = 0; i < MAX_DELIM_LEN; i++) begin
      if (FILL_W'(i) < len_eff && wk[i] != cfg.delim_bytes[8*i +: 8]) begin
        mismatch = 1'b1;
      end
    end
    for (int i = 0; i < MAX_DELIM_LEN - 1; i++) begin
      wk_pop[i] = wk[i+1];
    end
    wk_pop[MAX_DELIM_LEN-1] = wk[MAX_DELIM_LEN-1];
  end

  assign advance = cur.vld & (~out_vld_r | ~out_stall);

  // Step sequencer: one window step and at most one result beat per cycle
  always_comb begin
    win_nxt      = win_r;
    fill_nxt     = fill_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    cnt_nxt      = cnt_r;
    in_tok_nxt   = in_tok_r;
    phase_nxt    = phase_r;
    do_pop       = 1'b0;
    done         = 1'b0;
    emit         = 1'b0;
    emit_res     = '0;
    if (advance) begin
      win_nxt  = wk;
      fill_nxt = wf;
      case (phase_r)
        PH_ENTRY, PH_DRAIN: begin
          if (wf > len_eff) begin
            // window longer than the delimiter: drop the oldest byte out
            do_pop    = 1'b1;
            phase_nxt = PH_DRAIN;
          end else begin
            if (wf == len_eff) begin
              if (mismatch) begin
                do_pop = 1'b1;
              end else begin
                fill_nxt   = '0;
                in_tok_nxt = 1'b0;
              end
            end
            if (cur.last) begin
              phase_nxt = PH_FLUSH;
            end else begin
              phase_nxt = PH_ENTRY;
              done      = 1'b1;
            end
          end
        end
        PH_FLUSH: begin
          if (wf != '0) begin
            do_pop = 1'b1;
          end else begin
            // closing beat of the string
            emit = 1'b1;
            if (held_vld_r) begin
              emit_res = '{data: held_r, index: cnt_r, tend: 1'b1, send: 1'b1,
                           none: 1'b0};
            end else begin
              emit_res = '{data: 8'd0, index: 8'd0, tend: 1'b0, send: 1'b1,
                           none: 1'b1};
            end
            fill_nxt     = '0;
            held_vld_nxt = 1'b0;
            cnt_nxt      = '0;
            in_tok_nxt   = 1'b0;
            phase_nxt    = PH_ENTRY;
            done         = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_ENTRY;
        end
      endcase
      // Oldest window byte becomes a token byte; release the held one
      if (do_pop) begin
        win_nxt  = wk_pop;
        fill_nxt = wf - FILL_W'(1);
        if (held_vld_r) begin
          emit     = 1'b1;
          emit_res = '{data: held_r, index: cnt_r, tend: ~in_tok_r, send: 1'b0,
                       none: 1'b0};
          if (!in_tok_r && cnt_r < IDX_MAX) begin
            cnt_nxt = cnt_r + 8'd1;
          end
        end
        held_nxt     = wk[0];
        held_vld_nxt = 1'b1;
        in_tok_nxt   = 1'b1;
      end
    end
  end

  assign item_done = advance & done;

  // Result register: load a new beat, drop a taken one
  always_comb begin
    out_vld_nxt = out_vld_r & out_stall;
    out_nxt     = out_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
      out_nxt     = emit_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ENTRY;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      held_vld_r <= 1'b0;
      cnt_r      <= '0;
      in_tok_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      fill_r     <= fill_nxt;
      held_vld_r <= held_vld_nxt;
      cnt_r      <= cnt_nxt;
      in_tok_r   <= in_tok_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload holds no reset
  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    held_r <= held_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_r;

endmodule

/* hw/rtl/multichar_delimiter_splitter_top.sv */
// ----------------------------------------------------------------------------
// multichar_delimiter_splitter_top: splits a byte string at a 1..8 byte delimiter.
// Throughput: one byte per cycle unless results stall; a shortened delimiter adds a step per extra byte.
// A byte with in_last takes an entry step, a flush step per byte left in the window and a closing step.
// A popped byte is held until the next pop or closing beat releases it to the result register.
// Reset: control state clears, delimiter resets to one space, no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multichar_delimiter_splitter_top
  import mds_pkg::*;
#(
  parameter int MAX_DELIM_LEN = MAX_DELIM_LEN_DEF,
  parameter int MAX_TOKENS    = MAX_TOKENS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte,
  output logic [7:0]            out_token_index,
  output logic                  out_token_end,
  output logic                  out_string_end,
  output logic                  out_no_tokens
);

  cfg_t  cfg;
  item_t cur;
  logic  item_done;
  res_t  out_res;

  mds_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mds_in_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .item_done (item_done),
    .cur       (cur)
  );

  mds_core #(
    .MAX_DELIM_LEN (MAX_DELIM_LEN),
    .MAX_TOKENS    (MAX_TOKENS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cur       (cur),
    .item_done (item_done),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // Break the result beat out onto the ports
  assign out_byte        = out_res.data;
  assign out_token_index = out_res.index;
  assign out_token_end   = out_res.tend;
  assign out_string_end  = out_res.send;
  assign out_no_tokens   = out_res.none;

endmodule

/* hw/rtl/mds_checker.sv */
// ----------------------------------------------------------------------------
// mds_checker
// Port-level checks on the splitter's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multichar_delimiter_splitter_top_assert.svh"

module mds_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic [7:0] out_token_index,
  input logic       out_token_end,
  input logic       out_string_end,
  input logic       out_no_tokens
);

  // An empty string gives one closing beat with zero byte and index and no token end
  `MDS_ASSERT_SAME(a_no_tokens_shape, out_valid && out_no_tokens, out_string_end && out_byte == 8'd0 && out_token_index == 8'd0 && !out_token_end, "no_tokens beat is not a clean closing beat")

  // The closing beat of a string with tokens also closes its last token
  `MDS_ASSERT_SAME(a_close_ends_token, out_valid && out_string_end && !out_no_tokens, out_token_end, "string end without token end")

  // Hold a stalled beat
  `MDS_ASSERT_NEXT(a_stall_holds, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_token_index) && $stable(out_string_end), "stalled result beat changed")

endmodule

bind multichar_delimiter_splitter_top mds_checker u_mds_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte        (out_byte),
  .out_token_index (out_token_index),
  .out_token_end   (out_token_end),
  .out_string_end  (out_string_end),
  .out_no_tokens   (out_no_tokens)
);

/* dv/tb_multichar_delimiter_splitter_top.sv */
// ----------------------------------------------------------------------------
// tb_multichar_delimiter_splitter_top
// Self-checking bench for the delimiter splitter. A short table of directed
// beats runs first: field extremes, the no-token string, zero bytes, length
// codes out of range, a delimiter cut short at the string end, greedy
// matching and a length change in the middle of a string. Random strings
// follow, built from tokens, whole and partial delimiters, under several
// register settings, ending with one string of many short tokens. Each
// result is checked field by field against an in-bench model of the
// splitter, with random gaps on both sides of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multichar_delimiter_splitter_top;
  import mds_pkg::*;

  localparam int INDEX_MAX     = (MAX_TOKENS_DEF - 1 > 255) ? 255 : MAX_TOKENS_DEF - 1;
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD     = 300;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_BEATS   = 40;
  localparam int MANY_TOKENS   = 20;
  localparam logic [3:0] LEN_PLAN [RAND_PHASES] =
    '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd3, 4'd5, 4'd7};

  typedef enum logic {
    ROW_REG,
    ROW_BEAT
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        reg_sel;
    logic [63:0] value;
    bit          last;
    bit          typed;
    res_t        want;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_byte;
  logic                  in_last;
  logic                  out_valid;
  logic                  out_stall;
  logic [7:0]            out_byte;
  logic [7:0]            out_token_index;
  logic                  out_token_end;
  logic                  out_string_end;
  logic                  out_no_tokens;

  // Splitter model state and register copies
  logic [63:0] delim_chars   = DELIM_BYTES_RST;
  logic [3:0]  delim_len_reg = DELIM_LEN_RST;
  logic [7:0]  delim_window [MAX_DELIM_LEN_DEF];
  int unsigned window_count  = 0;
  logic [7:0]  held_char     = 8'd0;
  bit          held_live     = 1'b0;
  logic [7:0]  token_idx     = 8'd0;
  bit          mid_token     = 1'b0;

  res_t        due_token_bytes [$];
  plan_row_t   plan_rows [$];

  int          err_count       = 0;
  int          results_checked = 0;
  int          empty_strings   = 0;
  int          beats_sent      = 0;
  int          strings_sent    = 0;
  int          settings_seen   = 0;
  int          beat_results    = 0;
  bit          steady_source   = 1'b0;
  bit          steady_sink     = 1'b0;
  bit          hold_request    = 1'b0;

  multichar_delimiter_splitter_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_token_index (out_token_index),
    .out_token_end   (out_token_end),
    .out_string_end  (out_string_end),
    .out_no_tokens   (out_no_tokens)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  function automatic res_t mk_res(input logic [7:0] d, input logic [7:0] idx,
                                  input logic tend, input logic send,
                                  input logic none);
    res_t r;
    r.data  = d;
    r.index = idx;
    r.tend  = tend;
    r.send  = send;
    r.none  = none;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Length codes 0 and above the maximum are clamped
  function automatic int unsigned eff_len();
    if (delim_len_reg == 4'd0) return 1;
    if (delim_len_reg > 4'(MAX_DELIM_LEN_DEF)) return MAX_DELIM_LEN_DEF;
    return 32'(delim_len_reg);
  endfunction

  // Emit the held byte, then hold the new one
  function automatic void pass_token_byte(input logic [7:0] b);
    if (held_live) begin
      due_token_bytes.push_back(mk_res(held_char, token_idx, !mid_token, 1'b0, 1'b0));
      if (!mid_token && token_idx < 8'(INDEX_MAX)) token_idx++;
    end
    held_char = b;
    held_live = 1'b1;
    mid_token = 1'b1;
  endfunction

  function automatic void shift_out_oldest();
    logic [7:0] b;
    b = delim_window[0];
    for (int i = 1; i < window_count && i < MAX_DELIM_LEN_DEF; i++)
      delim_window[i-1] = delim_window[i];
    window_count--;
    pass_token_byte(b);
  endfunction

  // Advance the model by one accepted beat
  function automatic void predict_split(input logic [7:0] b, input bit last);
    int unsigned len;
    bit hit;
    len = eff_len();
    if (window_count < MAX_DELIM_LEN_DEF) begin
      delim_window[window_count] = b;
      window_count++;
    end
    while (window_count > len) shift_out_oldest();
    if (window_count == len) begin
      hit = 1'b1;
      for (int i = 0; i < len; i++)
        if (delim_window[i] != delim_chars[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        window_count = 0;
        mid_token    = 1'b0;
      end else begin
        shift_out_oldest();
      end
    end
    if (last) begin
      while (window_count > 0) shift_out_oldest();
      if (held_live) due_token_bytes.push_back(mk_res(held_char, token_idx, 1'b1, 1'b1, 1'b0));
      else due_token_bytes.push_back(mk_res(8'd0, 8'd0, 1'b0, 1'b1, 1'b1));
      window_count = 0;
      held_char    = 8'd0;
      held_live    = 1'b0;
      token_idx    = 8'd0;
      mid_token    = 1'b0;
    end
  endfunction

  // Offer one beat and hold it until the block takes it
  task automatic send_beat(input logic [7:0] b, input bit last);
    int gap;
    int n_pre;
    gap = steady_source ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Count the results this beat adds to the queue
    n_pre = due_token_bytes.size();
    predict_split(b, last);
    beat_results = due_token_bytes.size() - n_pre;
    beats_sent++;
    if (last) strings_sent++;
  endtask

  task automatic pause_source();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait for every due result, then let any flush finish
  task automatic wait_drained();
    while (due_token_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic reg_sel, input logic [63:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(reg_sel) << REG_SEL_BIT;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_sel == REG_DELIM_BYTES) delim_chars = data;
    else delim_len_reg = data[3:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mix delimiter characters into the random bytes to provoke partial matches
  function automatic logic [7:0] pick_char();
    int k;
    if ($urandom_range(0, 9) < 4) begin
      k = $urandom_range(0, eff_len() - 1);
      return delim_chars[8*k +: 8];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Build a string from tokens, delimiter runs and delimiter prefixes
  task automatic send_random_string(input int min_len, input int max_len);
    logic [7:0] chars [$];
    int n;
    int piece;
    int k;
    bit noise;
    n = $urandom_range(min_len, max_len);
    noise = ($urandom_range(0, 9) == 0);
    while (chars.size() < n) begin
      piece = $urandom_range(0, 9);
      if (noise) begin
        chars.push_back(8'($urandom_range(0, 255)));
      end else if (piece < 5) begin
        k = $urandom_range(1, 6);
        repeat (k) chars.push_back(pick_char());
      end else if (piece < 8) begin
        k = $urandom_range(1, 2) * eff_len();
        for (int i = 0; i < k; i++) chars.push_back(delim_chars[8*(i % eff_len()) +: 8]);
      end else begin
        k = $urandom_range(1, eff_len());
        for (int i = 0; i < k; i++) chars.push_back(delim_chars[8*i +: 8]);
      end
    end
    for (int i = 0; i < n; i++) send_beat(chars[i], i == n - 1);
  endtask

  function automatic void add_reg(input logic reg_sel, input logic [63:0] v);
    plan_row_t r;
    r.kind    = ROW_REG;
    r.reg_sel = reg_sel;
    r.value   = v;
    r.last    = 1'b0;
    r.typed   = 1'b0;
    r.want    = '0;
    plan_rows.push_back(r);
  endfunction

  function automatic void add_beat(input logic [7:0] c, input bit last,
                                   input bit typed = 1'b0, input res_t want = '0);
    plan_row_t r;
    r.kind    = ROW_BEAT;
    r.reg_sel = REG_DELIM_BYTES;
    r.value   = {56'd0, c};
    r.last    = last;
    r.typed   = typed;
    r.want    = want;
    plan_rows.push_back(r);
  endfunction

  // Result checker: compare each accepted beat with the oldest due result
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_token_bytes.size() == 0) begin
        $error("unexpected result beat: out_byte %0h, out_token_index %0d",
               out_byte, out_token_index);
        err_count++;
      end else begin
        want = due_token_bytes.pop_front();
        results_checked++;
        if (want.none) empty_strings++;
        if (out_byte !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, out_byte);
          err_count++;
        end
        if (out_token_index !== want.index) begin
          $error("out_token_index: expected %0d, got %0d", want.index, out_token_index);
          err_count++;
        end
        if (out_token_end !== want.tend) begin
          $error("out_token_end: expected %0b, got %0b", want.tend, out_token_end);
          err_count++;
        end
        if (out_string_end !== want.send) begin
          $error("out_string_end: expected %0b, got %0b", want.send, out_string_end);
          err_count++;
        end
        if (out_no_tokens !== want.none) begin
          $error("out_no_tokens: expected %0b, got %0b", want.none, out_no_tokens);
          err_count++;
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!steady_sink) stall_left = pick_gap();
      end
    end
  end

  // Stimulus
  initial begin
    logic [63:0] chars;
    logic [7:0]  sep;
    logic [7:0]  c;
    int          phase_start;

    rst_n    = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    in_byte  = 8'd0;
    in_last  = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table; typed rows hold results that are plain to see
    add_beat(8'h61, 1'b1, 1'b1, mk_res(8'h61, 8'd0, 1'b1, 1'b1, 1'b0));
    add_beat(8'h20, 1'b1, 1'b1, mk_res(8'h00, 8'd0, 1'b0, 1'b1, 1'b1));
    add_beat(8'h00, 1'b1, 1'b1, mk_res(8'h00, 8'd0, 1'b1, 1'b1, 1'b0));
    add_beat(8'hFF, 1'b1, 1'b1, mk_res(8'hFF, 8'd0, 1'b1, 1'b1, 1'b0));
    add_beat(8'h61, 1'b0);
    add_beat(8'h20, 1'b0);
    add_beat(8'h20, 1'b0);
    add_beat(8'h62, 1'b1);
    // zero delimiter, length code 0 acts as one byte
    add_reg(REG_DELIM_BYTES, 64'd0);
    add_reg(REG_DELIM_LEN, 64'd0);
    add_beat(8'h00, 1'b0);
    add_beat(8'h78, 1'b0);
    add_beat(8'h00, 1'b1);
    // length code 15 acts as eight, then shrink the delimiter mid-string
    add_reg(REG_DELIM_BYTES, '1);
    add_reg(REG_DELIM_LEN, 64'd15);
    add_beat(8'h7A, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_reg(REG_DELIM_LEN, 64'd2);
    add_beat(8'hFF, 1'b1);
    // delimiter cut short by the end of the string
    add_reg(REG_DELIM_BYTES, 64'h636261);
    add_reg(REG_DELIM_LEN, 64'd3);
    add_beat(8'h78, 1'b0);
    add_beat(8'h61, 1'b0);
    add_beat(8'h62, 1'b1);
    // greedy, non-overlapping match on a repeated character
    add_reg(REG_DELIM_BYTES, 64'h6161);
    add_reg(REG_DELIM_LEN, 64'd2);
    add_beat(8'h61, 1'b0);
    add_beat(8'h61, 1'b0);
    add_beat(8'h61, 1'b0);
    add_beat(8'h62, 1'b1);

    foreach (plan_rows[i]) begin
      if (plan_rows[i].kind == ROW_REG) begin
        pause_source();
        wait_drained();
        cfg_write(plan_rows[i].reg_sel, plan_rows[i].value);
        settings_seen++;
      end else begin
        send_beat(plan_rows[i].value[7:0], plan_rows[i].last);
        if (plan_rows[i].typed) begin
          repeat (beat_results) void'(due_token_bytes.pop_back());
          due_token_bytes.push_back(plan_rows[i].want);
        end
      end
    end

    // Random strings under a series of register settings
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      pause_source();
      wait_drained();
      case (phase)
        1: chars = '1;
        2: chars = '0;
        default: begin
          case (phase % 3)
            0: chars = {$urandom, $urandom};
            1: chars = {8{8'($urandom_range(0, 255))}};
            default: begin
              for (int i = 0; i < 8; i++) chars[8*i +: 8] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
            end
          endcase
        end
      endcase
      cfg_write(REG_DELIM_BYTES, chars);
      cfg_write(REG_DELIM_LEN, ({$urandom, $urandom} & ~64'hF) | 64'(LEN_PLAN[phase]));
      settings_seen++;
      steady_source = (phase == 3);
      steady_sink   = (phase == 3);
      phase_start   = beats_sent;

      // Hold off the result side while a long string keeps coming
      if (phase == 4) begin
        hold_request  = 1'b1;
        steady_source = 1'b1;
        send_random_string(40, 48);
        steady_source = 1'b0;
      end
      while (beats_sent - phase_start < PHASE_BEATS) begin
        send_random_string(1, 12);
        // Let the block run dry at least once midway through the phase before going on
        if (phase == 5 && beats_sent - phase_start >= PHASE_BEATS / 2 &&
            beats_sent - phase_start < PHASE_BEATS / 2 + 12) begin
          pause_source();
          while (due_token_bytes.size() != 0) @(posedge clk);
        end
      end
    end

    // One string of many single-byte tokens
    pause_source();
    wait_drained();
    sep = 8'($urandom_range(0, 255));
    cfg_write(REG_DELIM_BYTES, {$urandom, 24'($urandom), sep});
    cfg_write(REG_DELIM_LEN, 64'd1);
    settings_seen++;
    for (int i = 0; i < MANY_TOKENS; i++) begin
      c = 8'($urandom_range(0, 255));
      while (c == sep) c = 8'($urandom_range(0, 255));
      send_beat(c, 1'b0);
      send_beat(sep, i == MANY_TOKENS - 1);
    end

    pause_source();
    wait_drained();

    $display("Sent %0d beats in %0d strings over %0d register settings.",
             beats_sent, strings_sent, settings_seen);
    $display("Checked %0d results, %0d of them from token-free strings.",
             results_checked, empty_strings);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
